// ===== hw/rtl/owr_pkg.sv =====
// ----------------------------------------------------------------------------
// owr_pkg
// Shared types and constants for the overwrite ring with cumulative ack.
// ----------------------------------------------------------------------------
package owr_pkg;

  localparam int SEQ_W      = 32;
  localparam int PORT_PAY_W = 64;
  localparam int COUNT_W    = 8;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_ACK   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DROP,
    S_ACK_TEST,
    S_DONE
  } owr_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic rd_next;
    logic append;
    logic over;
    logic pop;
    logic sync_wr;
    logic emit;
  } owr_cmd_t;

  typedef struct packed {
    logic is_ack;
    logic full;
    logic empty;
    logic seq_le;
    logic out_free;
  } owr_status_t;

endpackage

// ===== hw/rtl/owr_if.sv =====
// ----------------------------------------------------------------------------
// owr_in_if / owr_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface owr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [owr_pkg::SEQ_W-1:0]      record_sequence;
  logic [owr_pkg::PORT_PAY_W-1:0] record_payload;
  logic [owr_pkg::SEQ_W-1:0]      acked_sequence;

  modport source (output valid, func, record_sequence, record_payload, acked_sequence,
                  input ready);
  modport sink   (input valid, func, record_sequence, record_payload, acked_sequence,
                  output ready);
endinterface

interface owr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        dropped;
  logic [owr_pkg::SEQ_W-1:0]   dropped_sequence;
  logic [owr_pkg::COUNT_W-1:0] removed_count;
  logic [owr_pkg::COUNT_W-1:0] queued_count;

  modport source (output valid, dropped, dropped_sequence, removed_count, queued_count,
                  input ready);
  modport sink   (input valid, dropped, dropped_sequence, removed_count, queued_count,
                  output ready);
endinterface

// ===== hw/rtl/overwrite_ring_with_cumulative_ack.sv =====
// ----------------------------------------------------------------------------
// overwrite_ring_with_cumulative_ack
// Ring of DEPTH sequenced records, overwrite-oldest on full, cumulative ack.
// ----------------------------------------------------------------------------
// ingress: one word per operation. func store writes record_sequence and the
//   low PAYLOAD_WIDTH bits of record_payload; func ack pops records from the
//   oldest end while their sequence <= acked_sequence (unsigned).
// egress: exactly one result word per ingress word, in order: dropped flag,
//   dropped_sequence, removed_count, queued_count (counts taken mod 256).
// Timing: a word is taken only while the block is idle. A store goes from
//   accept through S_START to S_DONE (through S_DROP as well when full: one
//   memory read of the oldest sequence). An ack goes through S_START and
//   S_ACK_TEST, where the compare loop handles one record per cycle off the
//   registered memory read. The next word is taken in the cycle after the
//   result is loaded.
// Reset: rst (sync, active high) empties the ring; record memory is not
//   cleared and holds no valid bits.
// Stall: the result sits in an output register; while egress.ready is low
//   the block finishes the next word and holds it until the register frees.
// ----------------------------------------------------------------------------
module overwrite_ring_with_cumulative_ack #(
  parameter int DEPTH         = 128,
  parameter int PAYLOAD_WIDTH = 64
) (
  input logic         clk,
  input logic         rst,
  owr_in_if.sink      ingress,
  owr_out_if.source   egress
);
  import owr_pkg::*;

  owr_cmd_t    cmd;
  owr_status_t status;

  owr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ingress.valid),
    .in_ready (ingress.ready),
    .status   (status),
    .cmd      (cmd)
  );

  owr_dp #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .status               (status),
    .in_func              (ingress.func),
    .in_sequence          (ingress.record_sequence),
    .in_payload           (ingress.record_payload[PAYLOAD_WIDTH-1:0]),
    .in_acked             (ingress.acked_sequence),
    .out_valid            (egress.valid),
    .out_ready            (egress.ready),
    .out_dropped          (egress.dropped),
    .out_dropped_sequence (egress.dropped_sequence),
    .out_removed_count    (egress.removed_count),
    .out_queued_count     (egress.queued_count)
  );

endmodule

// ===== hw/rtl/owr_ctrl.sv =====
// ----------------------------------------------------------------------------
// owr_ctrl
// Sequencer for store and ack words; drives datapath commands.
// ----------------------------------------------------------------------------
module owr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  owr_pkg::owr_status_t status,
  output owr_pkg::owr_cmd_t    cmd
);
  import owr_pkg::*;

  owr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.is_ack) begin
          cmd.rd     = 1'b1;
          state_next = S_ACK_TEST;
        end else if (status.full) begin
          cmd.rd     = 1'b1;
          state_next = S_DROP;
        end else begin
          cmd.append = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DROP: begin
        cmd.over   = 1'b1;
        state_next = S_DONE;
      end
      S_ACK_TEST: begin
        if (status.empty) begin
          cmd.sync_wr = 1'b1;
          state_next  = S_DONE;
        end else if (status.seq_le) begin
          cmd.pop     = 1'b1;
          cmd.rd      = 1'b1;
          cmd.rd_next = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/owr_dp.sv =====
// ----------------------------------------------------------------------------
// owr_dp
// Ring memories, pointers, counters and the result register.
// ----------------------------------------------------------------------------
module owr_dp #(
  parameter int DEPTH         = 128,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  owr_pkg::owr_cmd_t               cmd,
  output owr_pkg::owr_status_t            status,
  input  logic                            in_func,
  input  logic [owr_pkg::SEQ_W-1:0]       in_sequence,
  input  logic [PAYLOAD_WIDTH-1:0]        in_payload,
  input  logic [owr_pkg::SEQ_W-1:0]       in_acked,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_dropped,
  output logic [owr_pkg::SEQ_W-1:0]       out_dropped_sequence,
  output logic [owr_pkg::COUNT_W-1:0]     out_removed_count,
  output logic [owr_pkg::COUNT_W-1:0]     out_queued_count
);
  import owr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [SEQ_W-1:0]         mem_seq [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] mem_pay [DEPTH];

  logic                     func_q;
  logic [SEQ_W-1:0]         seq_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;
  logic [SEQ_W-1:0]         acked_q;
  logic [AW-1:0]            oldest;
  logic [AW-1:0]            wr;
  logic [CW-1:0]            count;
  logic [CW-1:0]            removed;
  logic [SEQ_W-1:0]         rd_data;
  logic                     drop_flag;
  logic [SEQ_W-1:0]         drop_seq;

  logic [AW-1:0] oldest_inc;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  assign oldest_inc = next_slot(oldest);
  assign rd_addr    = cmd.rd_next ? oldest_inc : oldest;
  assign wr_addr    = cmd.over ? oldest : wr;
  assign wr_en      = cmd.append | cmd.over;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_seq[wr_addr] <= seq_q;
      mem_pay[wr_addr] <= pay_q;
    end
    if (cmd.rd) begin
      rd_data <= mem_seq[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= in_func;
      seq_q   <= in_sequence;
      pay_q   <= in_payload;
      acked_q <= in_acked;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      wr        <= '0;
      count     <= '0;
      removed   <= '0;
      drop_flag <= 1'b0;
      drop_seq  <= '0;
    end else begin
      if (cmd.load) begin
        removed   <= '0;
        drop_flag <= 1'b0;
        drop_seq  <= '0;
      end
      if (cmd.append) begin
        count <= count + 1'b1;
        wr    <= next_slot(wr);
      end
      if (cmd.over) begin
        drop_flag <= 1'b1;
        drop_seq  <= rd_data;
        oldest    <= oldest_inc;
        wr        <= oldest_inc;
      end
      if (cmd.pop) begin
        oldest  <= oldest_inc;
        count   <= count - 1'b1;
        removed <= removed + 1'b1;
      end
      if (cmd.sync_wr) begin
        wr <= oldest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dropped          <= drop_flag;
      out_dropped_sequence <= drop_seq;
      out_removed_count    <= COUNT_W'(removed);
      out_queued_count     <= COUNT_W'(count);
    end
  end

  assign status.is_ack   = (func_q == FUNC_ACK);
  assign status.full     = (count == CW'(DEPTH));
  assign status.empty    = (count == '0);
  assign status.seq_le   = (rd_data <= acked_q);
  assign status.out_free = ~out_valid | out_ready;

endmodule

// ===== dv/ring_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_result_checker
// Watches both channels of the overwrite ring. It keeps its own copy of the
// ring's sequence slots and counters, works out the result word owed for
// every accepted input word, and compares each result word with the oldest
// one owed. Mismatches, result words with nothing owed, and the number of
// result words still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module ring_result_checker #(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  owr_in_if    in_ch,
  owr_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import owr_pkg::*;

  typedef struct packed {
    logic               dropped;
    logic [SEQ_W-1:0]   dropped_sequence;
    logic [COUNT_W-1:0] removed_count;
    logic [COUNT_W-1:0] queued_count;
  } ring_result_t;

  logic [SEQ_W-1:0] slot_seq [DEPTH];
  int unsigned      held;
  int unsigned      oldest;
  int unsigned      wr_slot;
  ring_result_t     owed_results [$];
  int               reported;

  initial begin
    fail_count = 0;
    pending    = 0;
    reported   = 0;
    held       = 0;
    oldest     = 0;
    wr_slot    = 0;
  end

  function automatic ring_result_t apply_word(logic f, logic [SEQ_W-1:0] seq,
                                              logic [SEQ_W-1:0] acked);
    ring_result_t r;
    r = '0;
    if (f == FUNC_STORE) begin
      if (held >= DEPTH) begin
        r.dropped          = 1'b1;
        r.dropped_sequence = slot_seq[oldest];
        slot_seq[oldest]   = seq;
        oldest             = (oldest + 1) % DEPTH;
        wr_slot            = oldest;
      end else begin
        slot_seq[wr_slot] = seq;
        held++;
        wr_slot = (wr_slot + 1) % DEPTH;
      end
    end else begin
      // stops at the first record above the ack, later ones not examined
      while (held > 0 && slot_seq[oldest] <= acked) begin
        oldest = (oldest + 1) % DEPTH;
        held--;
        r.removed_count++;
      end
      if (held == 0)
        wr_slot = oldest;
    end
    r.queued_count = COUNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    ring_result_t want;
    ring_result_t got;
    if (rst) begin
      held    = 0;
      oldest  = 0;
      wr_slot = 0;
      owed_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        owed_results.push_back(apply_word(in_ch.func, in_ch.record_sequence,
                                          in_ch.acked_sequence));
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.dropped, out_ch.dropped_sequence, out_ch.removed_count,
               out_ch.queued_count};
        if (owed_results.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result word with none owed: drop=%0b dseq=%h rm=%0d q=%0d",
                     $realtime, got.dropped, got.dropped_sequence, got.removed_count,
                     got.queued_count);
          end
        end else begin
          want = owed_results.pop_front();
          if (got.dropped !== want.dropped ||
              got.dropped_sequence !== want.dropped_sequence ||
              got.removed_count !== want.removed_count ||
              got.queued_count !== want.queued_count) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch exp drop=%0b dseq=%h rm=%0d q=%0d", $realtime,
                       want.dropped, want.dropped_sequence, want.removed_count,
                       want.queued_count);
              $display("%0t:          got drop=%0b dseq=%h rm=%0d q=%0d", $realtime,
                       got.dropped, got.dropped_sequence, got.removed_count,
                       got.queued_count);
            end
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

// ===== dv/tb_overwrite_ring_with_cumulative_ack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_overwrite_ring_with_cumulative_ack
// Drives store and ack words into the overwrite ring: a directed opening on
// empty rings, extreme fields and out-of-order sequences, then random bursts
// of rising sequences with acks near the recent ones, fills past full, and
// noise. Both channels idle at random. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_overwrite_ring_with_cumulative_ack;
  import owr_pkg::*;

  localparam int RING_DEPTH  = 128;
  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle_count;
  bit   calm;
  int   sent;
  logic [SEQ_W-1:0] next_seq;

  owr_in_if  in_ch ();
  owr_out_if out_ch ();

  overwrite_ring_with_cumulative_ack #(
    .DEPTH        (RING_DEPTH),
    .PAYLOAD_WIDTH(PORT_PAY_W)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .ingress(in_ch),
    .egress (out_ch)
  );

  ring_result_checker #(
    .DEPTH(RING_DEPTH)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.func            = FUNC_STORE;
    in_ch.record_sequence = '0;
    in_ch.record_payload  = '0;
    in_ch.acked_sequence  = '0;
    out_ch.ready          = 1'b0;
  end

  always @(negedge clk)
    out_ch.ready <= calm || ($urandom_range(99) >= 14);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(logic f, logic [SEQ_W-1:0] seq,
                           logic [PORT_PAY_W-1:0] pay, logic [SEQ_W-1:0] acked);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid           = 1'b1;
    in_ch.func            = f;
    in_ch.record_sequence = seq;
    in_ch.record_payload  = pay;
    in_ch.acked_sequence  = acked;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic store_rec(logic [SEQ_W-1:0] seq);
    send_word(FUNC_STORE, seq, {$urandom, $urandom}, $urandom);
  endtask

  task automatic ack_to(logic [SEQ_W-1:0] acked);
    send_word(FUNC_ACK, $urandom, {$urandom, $urandom}, acked);
  endtask

  task automatic store_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        store_rec($urandom);
      end else begin
        store_rec(next_seq);
        next_seq += $urandom_range(0, 3);
      end
    end
  endtask

  initial begin
    int kind;
    cycle_count = 0;
    calm        = 1'b0;
    sent        = 0;
    rst         = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty ring acks
    ack_to('0);
    ack_to('1);
    // extremes; ack below the max record stops there
    send_word(FUNC_STORE, '0, '0, '1);
    send_word(FUNC_STORE, '1, '1, '0);
    send_word(FUNC_ACK, '1, '1, '0);
    send_word(FUNC_ACK, '0, '0, '1);
    // out-of-order records: a later smaller sequence is not examined
    store_rec(32'd10);
    store_rec(32'd5);
    store_rec(32'd20);
    ack_to(32'd7);
    ack_to(32'd10);
    ack_to(32'hFFFF_FFFE);
    send_word(FUNC_STORE, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_word(FUNC_STORE, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 32'h5555_5555);
    send_word(FUNC_ACK, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 32'h5555_5555);
    ack_to('1);

    next_seq = $urandom_range(0, 1000);
    sent     = 0;
    // fill past full so stores overwrite the oldest
    store_burst(RING_DEPTH + $urandom_range(4, 12));
    while (sent < RANDOM_WORDS) begin
      calm = (sent >= 200 && sent < 280);
      if (sent >= 220 && sent < 221)
        store_burst(RING_DEPTH + $urandom_range(1, 8));
      kind = $urandom_range(9);
      if (kind <= 5) begin
        store_burst($urandom_range(1, 24));
      end else if (kind <= 8) begin
        ack_to(next_seq - $urandom_range(0, 40));
      end else begin
        case ($urandom_range(2))
          0:       ack_to($urandom);
          1:       ack_to('0);
          default: ack_to('1);
        endcase
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending != 0)
      @(posedge clk);
    repeat (RING_DEPTH + 16) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
